// ----- hdl/rim_pkg.sv -----
package rim_pkg;

  typedef logic [7:0]  refs_t;
  typedef logic [31:0] cnt_t;
  typedef logic [47:0] tstamp_t;
  typedef logic [31:0] delay_t;

  localparam logic [2:0] REQ_TICK         = 3'd0;
  localparam logic [2:0] REQ_GET          = 3'd1;
  localparam logic [2:0] REQ_PUT          = 3'd2;
  localparam logic [2:0] REQ_TOUCH        = 3'd3;
  localparam logic [2:0] REQ_WAKE         = 3'd4;
  localparam logic [2:0] REQ_FORCE_IDLE   = 3'd5;
  localparam logic [2:0] REQ_FORCE_ACTIVE = 3'd6;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSOLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY    = 2'd2;

  localparam delay_t DELAY_RESET = 32'd30000;

  typedef struct packed {
    logic [2:0] req_type;
    logic       caller_holds;
  } in_word_t;

  typedef struct packed {
    logic    idle_now;
    logic    screen_off;
    logic    black_frame;
    logic    screen_on;
    logic    repaint_request;
    refs_t   refs_held;
    logic    caller_holds_after;
    cnt_t    idle_entries;
    cnt_t    wake_entries;
    cnt_t    touch_wakes;
    tstamp_t idle_time_total;
    tstamp_t active_time_total;
  } out_word_t;

  typedef struct packed {
    delay_t idle_delay_ticks;
    logic   console_mode;
    logic   display_present;
  } cfg_t;

endpackage

// ----- hdl/rim_cfg_regs.sv -----
module rim_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rim_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rim_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output rim_pkg::cfg_t                   cfg_o
);

  rim_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rim_pkg::CFG_IDLE_DELAY: cfg_d.idle_delay_ticks = rim_pkg::delay_t'(cfg_data_i);
        rim_pkg::CFG_CONSOLE:    cfg_d.console_mode     = cfg_data_i[0];
        rim_pkg::CFG_DISPLAY:    cfg_d.display_present  = cfg_data_i[0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_delay_ticks <= rim_pkg::DELAY_RESET;
      cfg_q.console_mode     <= 1'b0;
      cfg_q.display_present  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hdl/rim_engine.sv -----
module rim_engine #(
  parameter int unsigned REF_WIDTH   = 8,
  parameter int unsigned TIME_WIDTH  = 48,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  rim_pkg::in_word_t  item_i,
  input  rim_pkg::cfg_t      cfg_i,
  output rim_pkg::out_word_t res_o
);

  logic                   idle_q, idle_d;
  logic [REF_WIDTH-1:0]   ref_q, ref_d;
  logic                   armed_q, armed_d;
  rim_pkg::delay_t        cd_q, cd_d;
  logic [TIME_WIDTH-1:0]  elapsed_q, elapsed_d;
  logic [TIME_WIDTH-1:0]  idle_acc_q, idle_acc_d;
  logic [TIME_WIDTH-1:0]  act_acc_q, act_acc_d;
  logic [COUNT_WIDTH-1:0] idle_cnt_q, idle_cnt_d;
  logic [COUNT_WIDTH-1:0] wake_cnt_q, wake_cnt_d;
  logic [COUNT_WIDTH-1:0] touch_cnt_q, touch_cnt_d;

  logic                  may_arm, is_tick, chg, to_idle, by_touch;
  logic                  off, black, on, repaint, holds_after;
  logic [TIME_WIDTH-1:0] elapsed_use;

  assign may_arm     = !cfg_i.console_mode && (cfg_i.idle_delay_ticks != '0);
  assign is_tick     = (item_i.req_type == rim_pkg::REQ_TICK);
  assign elapsed_use = elapsed_q + TIME_WIDTH'(is_tick);

  always_comb begin
    ref_d       = ref_q;
    armed_d     = armed_q;
    cd_d        = cd_q;
    chg         = 1'b0;
    to_idle     = 1'b0;
    by_touch    = 1'b0;
    off         = 1'b0;
    black       = 1'b0;
    on          = 1'b0;
    repaint     = 1'b0;
    holds_after = item_i.caller_holds;

    unique case (item_i.req_type)
      rim_pkg::REQ_TICK: begin
        if (armed_q) begin
          if (cd_q[31:1] == '0) begin
            armed_d = 1'b0;
            cd_d    = '0;
            if (!idle_q) begin
              chg     = 1'b1;
              to_idle = 1'b1;
              black   = cfg_i.display_present;
              off     = 1'b1;
            end
          end else begin
            cd_d = cd_q - 32'd1;
          end
        end
      end
      rim_pkg::REQ_GET: begin
        if (ref_q != '1) ref_d = ref_q + REF_WIDTH'(1);
        holds_after = 1'b1;
        if (!cfg_i.console_mode) begin
          armed_d = 1'b0;
          cd_d    = '0;
          if (idle_q) begin
            chg = 1'b1;
            on  = 1'b1;
          end
        end
      end
      rim_pkg::REQ_PUT: begin
        holds_after = 1'b0;
        if (item_i.caller_holds && ref_q != '0) begin
          ref_d = ref_q - REF_WIDTH'(1);
          if (ref_q == REF_WIDTH'(1) && may_arm && !armed_q) begin
            armed_d = 1'b1;
            cd_d    = cfg_i.idle_delay_ticks;
          end
        end
      end
      rim_pkg::REQ_TOUCH: begin
        if (may_arm && ref_q == '0) begin
          armed_d = 1'b1;
          cd_d    = cfg_i.idle_delay_ticks;
        end
      end
      rim_pkg::REQ_WAKE: begin
        if (idle_q) begin
          chg      = 1'b1;
          by_touch = 1'b1;
          on       = 1'b1;
          repaint  = 1'b1;
          if (may_arm && ref_q == '0 && !armed_q) begin
            armed_d = 1'b1;
            cd_d    = cfg_i.idle_delay_ticks;
          end
        end
      end
      rim_pkg::REQ_FORCE_IDLE: begin
        armed_d = 1'b0;
        cd_d    = '0;
        if (!idle_q) begin
          chg     = 1'b1;
          to_idle = 1'b1;
          off     = 1'b1;
        end
      end
      rim_pkg::REQ_FORCE_ACTIVE: begin
        armed_d = 1'b0;
        cd_d    = '0;
        if (idle_q) begin
          chg = 1'b1;
          on  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idle_d      = idle_q;
    elapsed_d   = elapsed_use;
    idle_acc_d  = idle_acc_q;
    act_acc_d   = act_acc_q;
    idle_cnt_d  = idle_cnt_q;
    wake_cnt_d  = wake_cnt_q;
    touch_cnt_d = touch_cnt_q;
    if (chg) begin
      if (idle_q) idle_acc_d = idle_acc_q + elapsed_use;
      else        act_acc_d  = act_acc_q + elapsed_use;
      elapsed_d = '0;
      idle_d    = to_idle;
      if (to_idle) begin
        idle_cnt_d = idle_cnt_q + COUNT_WIDTH'(1);
      end else begin
        wake_cnt_d = wake_cnt_q + COUNT_WIDTH'(1);
        if (by_touch) touch_cnt_d = touch_cnt_q + COUNT_WIDTH'(1);
      end
    end
  end

  always_comb begin
    res_o.idle_now           = idle_d;
    res_o.screen_off         = off;
    res_o.black_frame        = black;
    res_o.screen_on          = on;
    res_o.repaint_request    = repaint;
    res_o.refs_held          = rim_pkg::refs_t'(ref_d);
    res_o.caller_holds_after = holds_after;
    res_o.idle_entries       = rim_pkg::cnt_t'(idle_cnt_d);
    res_o.wake_entries       = rim_pkg::cnt_t'(wake_cnt_d);
    res_o.touch_wakes        = rim_pkg::cnt_t'(touch_cnt_d);
    res_o.idle_time_total    = rim_pkg::tstamp_t'(idle_acc_d);
    res_o.active_time_total  = rim_pkg::tstamp_t'(act_acc_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q      <= 1'b0;
      ref_q       <= '0;
      armed_q     <= 1'b0;
      cd_q        <= '0;
      elapsed_q   <= '0;
      idle_acc_q  <= '0;
      act_acc_q   <= '0;
      idle_cnt_q  <= '0;
      wake_cnt_q  <= '0;
      touch_cnt_q <= '0;
    end else if (fire_i) begin
      idle_q      <= idle_d;
      ref_q       <= ref_d;
      armed_q     <= armed_d;
      cd_q        <= cd_d;
      elapsed_q   <= elapsed_d;
      idle_acc_q  <= idle_acc_d;
      act_acc_q   <= act_acc_d;
      idle_cnt_q  <= idle_cnt_d;
      wake_cnt_q  <= wake_cnt_d;
      touch_cnt_q <= touch_cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_black_needs_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.black_frame |-> res_o.screen_off)
    else $error("black frame without screen off");

  a_armed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> cd_q != '0)
    else $error("countdown armed at zero");

  a_idle_entry_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !idle_q && idle_d |=> idle_cnt_q == $past(idle_cnt_q) + COUNT_WIDTH'(1))
    else $error("idle entry not counted");

  a_flag_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i |=> idle_q == $past(res_o.idle_now))
    else $error("idle flag differs from reported value");
`endif

endmodule

// ----- hdl/refcounted_idle_manager_core.sv -----
// Refcounted display idle manager.
// Input channel (in_valid_i / in_stall_o / in_data_i): one event word per
// accepted cycle: tick, ref get/put, touch activity, touch wake, force idle,
// force active. Output channel (out_valid_o / out_stall_i / out_data_o): one
// result word per event, in order, with the idle flag, the screen pulses,
// the reference count and the transition statistics after that event.
// Config channel (cfg_valid_i / cfg_ready_o): register index and data, always
// ready; write only while no event is in flight.
// Path: an accepted word goes into the input register, then through a
// single-pass state update into the result register.
// Throughput: one event per cycle while the result is not stalled; the state
// update is one pass of compares and adds into the result register.
// Stall: a stalled result holds; the input register takes one more word, then
// in_stall_o rises until the result is taken.
// Reset: active, zero references, countdown disarmed, all counters zero,
// idle delay 30000 ticks, console mode off, display present.
module refcounted_idle_manager_core #(
  parameter int unsigned REF_WIDTH   = 8,
  parameter int unsigned TIME_WIDTH  = 48,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rim_pkg::in_word_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rim_pkg::out_word_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rim_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rim_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rim_pkg::cfg_t      cfg;
  rim_pkg::in_word_t  in_data_q;
  rim_pkg::out_word_t out_data_q, res;
  logic               in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic               advance, fire, in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  rim_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rim_engine #(
    .REF_WIDTH   (REF_WIDTH),
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)   in_valid_d = 1'b1;
    else if (fire) in_valid_d = 1'b0;
    out_valid_d = advance ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) in_data_q  <= in_data_i;
    if (fire)    out_data_q <= res;
  end

`ifndef SYNTHESIS
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q))
    else $error("pending input word lost");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic [rim_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rim_pkg::in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rim_pkg::out_word_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [rim_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [rim_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  refcounted_idle_manager_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int unsigned gap_pct = 18;
  int unsigned stall_pct = 60;
  int unsigned errors = 0;
  rim_pkg::out_word_t status_q[$];

  // shadow of the idle manager
  rim_pkg::delay_t  cfg_delay = rim_pkg::DELAY_RESET;
  logic             cfg_console = 1'b0;
  logic             cfg_display = 1'b1;
  logic             disp_idle = 1'b0;
  rim_pkg::refs_t   ref_cnt = '0;
  logic             cd_armed = 1'b0;
  rim_pkg::delay_t  cd_left = '0;
  rim_pkg::tstamp_t now_ticks = '0;
  rim_pkg::tstamp_t last_change = '0;
  rim_pkg::tstamp_t idle_acc = '0;
  rim_pkg::tstamp_t active_acc = '0;
  rim_pkg::cnt_t    n_idle = '0;
  rim_pkg::cnt_t    n_wake = '0;
  rim_pkg::cnt_t    n_touch_wake = '0;

  function automatic logic arm_allowed();
    return !cfg_console && cfg_delay != '0;
  endfunction

  function automatic void switch_state(logic to_idle, logic by_touch);
    rim_pkg::tstamp_t elapsed;
    elapsed = now_ticks - last_change;
    if (disp_idle) idle_acc = idle_acc + elapsed;
    else active_acc = active_acc + elapsed;
    last_change = now_ticks;
    if (to_idle) begin
      n_idle = n_idle + 1'b1;
    end else begin
      n_wake = n_wake + 1'b1;
      if (by_touch) n_touch_wake = n_touch_wake + 1'b1;
    end
    disp_idle = to_idle;
  endfunction

  function automatic void arm_countdown();
    cd_armed = 1'b1;
    cd_left = cfg_delay;
  endfunction

  function automatic void cancel_countdown();
    cd_armed = 1'b0;
    cd_left = '0;
  endfunction

  function automatic rim_pkg::out_word_t next_status(rim_pkg::in_word_t w);
    rim_pkg::out_word_t r;
    r = '0;
    r.caller_holds_after = w.caller_holds;
    case (w.req_type)
      rim_pkg::REQ_TICK: begin
        now_ticks = now_ticks + 1'b1;
        if (cd_armed) begin
          if (cd_left <= 1) begin
            cancel_countdown();
            if (!disp_idle) begin
              switch_state(1'b1, 1'b0);
              r.black_frame = cfg_display;
              r.screen_off = 1'b1;
            end
          end else begin
            cd_left = cd_left - 1'b1;
          end
        end
      end
      rim_pkg::REQ_GET: begin
        if (ref_cnt != '1) ref_cnt = ref_cnt + 1'b1;
        r.caller_holds_after = 1'b1;
        if (!cfg_console) begin
          cancel_countdown();
          if (disp_idle) begin
            switch_state(1'b0, 1'b0);
            r.screen_on = 1'b1;
          end
        end
      end
      rim_pkg::REQ_PUT: begin
        r.caller_holds_after = 1'b0;
        if (w.caller_holds && ref_cnt != '0) begin
          ref_cnt = ref_cnt - 1'b1;
          if (ref_cnt == '0 && arm_allowed() && !cd_armed) arm_countdown();
        end
      end
      rim_pkg::REQ_TOUCH: begin
        if (arm_allowed() && ref_cnt == '0) arm_countdown();
      end
      rim_pkg::REQ_WAKE: begin
        if (disp_idle) begin
          switch_state(1'b0, 1'b1);
          r.screen_on = 1'b1;
          r.repaint_request = 1'b1;
          if (arm_allowed() && ref_cnt == '0 && !cd_armed) arm_countdown();
        end
      end
      rim_pkg::REQ_FORCE_IDLE: begin
        cancel_countdown();
        if (!disp_idle) begin
          switch_state(1'b1, 1'b0);
          r.screen_off = 1'b1;
        end
      end
      rim_pkg::REQ_FORCE_ACTIVE: begin
        cancel_countdown();
        if (disp_idle) begin
          switch_state(1'b0, 1'b0);
          r.screen_on = 1'b1;
        end
      end
      default: ;
    endcase
    r.idle_now = disp_idle;
    r.refs_held = ref_cnt;
    r.idle_entries = n_idle;
    r.wake_entries = n_wake;
    r.touch_wakes = n_touch_wake;
    r.idle_time_total = idle_acc;
    r.active_time_total = active_acc;
    return r;
  endfunction

  function automatic int unsigned count_mismatches(rim_pkg::out_word_t e,
                                                   rim_pkg::out_word_t a);
    int unsigned n;
    n = 0;
    if (e.idle_now !== a.idle_now) begin
      $error("idle_now: expected %0h, got %0h", e.idle_now, a.idle_now); n++;
    end
    if (e.screen_off !== a.screen_off) begin
      $error("screen_off: expected %0h, got %0h", e.screen_off, a.screen_off); n++;
    end
    if (e.black_frame !== a.black_frame) begin
      $error("black_frame: expected %0h, got %0h", e.black_frame, a.black_frame); n++;
    end
    if (e.screen_on !== a.screen_on) begin
      $error("screen_on: expected %0h, got %0h", e.screen_on, a.screen_on); n++;
    end
    if (e.repaint_request !== a.repaint_request) begin
      $error("repaint_request: expected %0h, got %0h", e.repaint_request,
             a.repaint_request); n++;
    end
    if (e.refs_held !== a.refs_held) begin
      $error("refs_held: expected %0h, got %0h", e.refs_held, a.refs_held); n++;
    end
    if (e.caller_holds_after !== a.caller_holds_after) begin
      $error("caller_holds_after: expected %0h, got %0h", e.caller_holds_after,
             a.caller_holds_after); n++;
    end
    if (e.idle_entries !== a.idle_entries) begin
      $error("idle_entries: expected %0h, got %0h", e.idle_entries, a.idle_entries); n++;
    end
    if (e.wake_entries !== a.wake_entries) begin
      $error("wake_entries: expected %0h, got %0h", e.wake_entries, a.wake_entries); n++;
    end
    if (e.touch_wakes !== a.touch_wakes) begin
      $error("touch_wakes: expected %0h, got %0h", e.touch_wakes, a.touch_wakes); n++;
    end
    if (e.idle_time_total !== a.idle_time_total) begin
      $error("idle_time_total: expected %0h, got %0h", e.idle_time_total,
             a.idle_time_total); n++;
    end
    if (e.active_time_total !== a.active_time_total) begin
      $error("active_time_total: expected %0h, got %0h", e.active_time_total,
             a.active_time_total); n++;
    end
    return n;
  endfunction

  always @(posedge clk_i) begin : result_check
    rim_pkg::out_word_t exp_word;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (status_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        exp_word = status_q.pop_front();
        errors += count_mismatches(exp_word, out_data_o);
      end
    end
  end

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  function automatic rim_pkg::in_word_t mk_word(logic [2:0] req, logic holds);
    rim_pkg::in_word_t w;
    w.req_type = req;
    w.caller_holds = holds;
    return w;
  endfunction

  function automatic rim_pkg::in_word_t rand_word();
    int unsigned p;
    rim_pkg::in_word_t w;
    p = $urandom_range(99);
    w.caller_holds = 1'($urandom_range(1));
    if (p < 40) w.req_type = rim_pkg::REQ_TICK;
    else if (p < 52) w.req_type = rim_pkg::REQ_GET;
    else if (p < 68) begin
      w.req_type = rim_pkg::REQ_PUT;
      w.caller_holds = ($urandom_range(99) < 85);
    end
    else if (p < 76) w.req_type = rim_pkg::REQ_TOUCH;
    else if (p < 84) w.req_type = rim_pkg::REQ_WAKE;
    else if (p < 89) w.req_type = rim_pkg::REQ_FORCE_IDLE;
    else if (p < 94) w.req_type = rim_pkg::REQ_FORCE_ACTIVE;
    else w.req_type = REQ_UNUSED;
    return w;
  endfunction

  function automatic rim_pkg::delay_t rand_delay();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 70) return rim_pkg::delay_t'($urandom_range(12, 1));
    if (p < 80) return '0;
    if (p < 90) return rim_pkg::delay_t'($urandom_range(60, 13));
    return rim_pkg::delay_t'($urandom);
  endfunction

  // enter at a falling edge, return at a falling edge with valid still high
  task automatic send_word(rim_pkg::in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
    status_q.push_back(next_status(w));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [rim_pkg::CFG_IDX_W-1:0] idx,
                           logic [rim_pkg::CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      rim_pkg::CFG_IDLE_DELAY: cfg_delay = data;
      rim_pkg::CFG_CONSOLE:    cfg_console = data[0];
      rim_pkg::CFG_DISPLAY:    cfg_display = data[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(rim_pkg::delay_t delay, logic console, logic display);
    write_reg(rim_pkg::CFG_IDLE_DELAY, delay);
    write_reg(rim_pkg::CFG_CONSOLE, {1'($urandom_range(1)), 30'($urandom), console});
    write_reg(rim_pkg::CFG_DISPLAY, {1'($urandom_range(1)), 30'($urandom), display});
    write_reg(CFG_SPARE, $urandom);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_word(rand_word());
  endtask

  task automatic test_directed();
    set_config(32'd2, 1'b0, 1'b1);
    send_word(mk_word(REQ_UNUSED, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_GET, 1'b0));
    send_word(mk_word(rim_pkg::REQ_GET, 1'b1));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b0));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_WAKE, 1'b0));
    send_word(mk_word(rim_pkg::REQ_TOUCH, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_GET, 1'b0));
    send_word(mk_word(rim_pkg::REQ_FORCE_IDLE, 1'b0));
    send_word(mk_word(rim_pkg::REQ_FORCE_IDLE, 1'b1));
    send_word(mk_word(rim_pkg::REQ_GET, 1'b1));
    send_word(mk_word(rim_pkg::REQ_FORCE_ACTIVE, 1'b0));
    send_word(mk_word(rim_pkg::REQ_WAKE, 1'b1));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TOUCH, 1'b0));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_FORCE_ACTIVE, 1'b1));
    drain();
  endtask

  task automatic test_console_mode();
    set_config(32'd1, 1'b1, 1'b1);
    send_word(mk_word(rim_pkg::REQ_FORCE_IDLE, 1'b0));
    send_word(mk_word(rim_pkg::REQ_GET, 1'b0));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TOUCH, 1'b0));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_WAKE, 1'b1));
    run_random(36);
    drain();
  endtask

  task automatic test_no_display();
    set_config(32'd1, 1'b0, 1'b0);
    send_word(mk_word(rim_pkg::REQ_GET, 1'b0));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    run_random(36);
    drain();
  endtask

  task automatic test_zero_delay();
    set_config('0, 1'b0, 1'b1);
    send_word(mk_word(rim_pkg::REQ_GET, 1'b1));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TOUCH, 1'b0));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_FORCE_IDLE, 1'b0));
    send_word(mk_word(rim_pkg::REQ_WAKE, 1'b0));
    run_random(34);
    drain();
  endtask

  task automatic test_max_delay();
    set_config('1, 1'b0, 1'b1);
    send_word(mk_word(rim_pkg::REQ_GET, 1'b0));
    send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    send_word(mk_word(rim_pkg::REQ_TICK, 1'b0));
    send_word(mk_word(rim_pkg::REQ_TOUCH, 1'b0));
    run_random(36);
    drain();
  endtask

  task automatic test_ref_saturation();
    set_config(32'd3, 1'b0, 1'b1);
    repeat (262) send_word(mk_word(rim_pkg::REQ_GET, 1'($urandom_range(1))));
    repeat (5) send_word(mk_word(rim_pkg::REQ_PUT, 1'b1));
    repeat (3) send_word(mk_word(rim_pkg::REQ_GET, 1'b0));
    drain();
  endtask

  task automatic test_random(int unsigned gap, int unsigned stall);
    gap_pct = gap;
    stall_pct = stall;
    repeat (4) begin
      set_config(rand_delay(), ($urandom_range(99) < 15), 1'($urandom_range(1)));
      run_random(40);
      drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_console_mode();
    test_no_display();
    test_zero_delay();
    test_max_delay();
    test_ref_saturation();
    test_random(18, 60);
    test_random(60, 18);
    test_random(0, 0);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/rim_pkg.sv
hdl/rim_cfg_regs.sv
hdl/rim_engine.sv
hdl/refcounted_idle_manager_core.sv
dv/testbench.sv
